// File: hdl/imadec_pkg.sv
package imadec_pkg;

    localparam int PositionBitsDefault = 24;

    localparam int SampleBits = 16;
    localparam int IndexBits  = 7;
    localparam int LoopBits   = 16;

    localparam logic [IndexBits-1:0] MaxIndex = 7'd88;

    localparam logic signed [17:0] SampleMax = 18'sd32767;
    localparam logic signed [17:0] SampleMin = -18'sd32767;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_NIBBLE  = 2'd1,
        KIND_RESTORE = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    function automatic logic [15:0] step_size(input logic [IndexBits-1:0] idx);
        logic [15:0] s;
        case (idx)
            7'd0:  s = 16'h0007;  7'd1:  s = 16'h0008;  7'd2:  s = 16'h0009;
            7'd3:  s = 16'h000A;  7'd4:  s = 16'h000B;  7'd5:  s = 16'h000C;
            7'd6:  s = 16'h000D;  7'd7:  s = 16'h000E;  7'd8:  s = 16'h0010;
            7'd9:  s = 16'h0011;  7'd10: s = 16'h0013;  7'd11: s = 16'h0015;
            7'd12: s = 16'h0017;  7'd13: s = 16'h0019;  7'd14: s = 16'h001C;
            7'd15: s = 16'h001F;  7'd16: s = 16'h0022;  7'd17: s = 16'h0025;
            7'd18: s = 16'h0029;  7'd19: s = 16'h002D;  7'd20: s = 16'h0032;
            7'd21: s = 16'h0037;  7'd22: s = 16'h003C;  7'd23: s = 16'h0042;
            7'd24: s = 16'h0049;  7'd25: s = 16'h0050;  7'd26: s = 16'h0058;
            7'd27: s = 16'h0061;  7'd28: s = 16'h006B;  7'd29: s = 16'h0076;
            7'd30: s = 16'h0082;  7'd31: s = 16'h008F;  7'd32: s = 16'h009D;
            7'd33: s = 16'h00AD;  7'd34: s = 16'h00BE;  7'd35: s = 16'h00D1;
            7'd36: s = 16'h00E6;  7'd37: s = 16'h00FD;  7'd38: s = 16'h0117;
            7'd39: s = 16'h0133;  7'd40: s = 16'h0151;  7'd41: s = 16'h0173;
            7'd42: s = 16'h0198;  7'd43: s = 16'h01C1;  7'd44: s = 16'h01EE;
            7'd45: s = 16'h0220;  7'd46: s = 16'h0256;  7'd47: s = 16'h0292;
            7'd48: s = 16'h02D4;  7'd49: s = 16'h031C;  7'd50: s = 16'h036C;
            7'd51: s = 16'h03C3;  7'd52: s = 16'h0424;  7'd53: s = 16'h048E;
            7'd54: s = 16'h0502;  7'd55: s = 16'h0583;  7'd56: s = 16'h0610;
            7'd57: s = 16'h06AB;  7'd58: s = 16'h0756;  7'd59: s = 16'h0812;
            7'd60: s = 16'h08E0;  7'd61: s = 16'h09C3;  7'd62: s = 16'h0ABD;
            7'd63: s = 16'h0BD0;  7'd64: s = 16'h0CFF;  7'd65: s = 16'h0E4C;
            7'd66: s = 16'h0FBA;  7'd67: s = 16'h114C;  7'd68: s = 16'h1307;
            7'd69: s = 16'h14EE;  7'd70: s = 16'h1706;  7'd71: s = 16'h1954;
            7'd72: s = 16'h1BDC;  7'd73: s = 16'h1EA5;  7'd74: s = 16'h21B6;
            7'd75: s = 16'h2515;  7'd76: s = 16'h28CA;  7'd77: s = 16'h2CDF;
            7'd78: s = 16'h315B;  7'd79: s = 16'h364B;  7'd80: s = 16'h3BB9;
            7'd81: s = 16'h41B2;  7'd82: s = 16'h4844;  7'd83: s = 16'h4F7E;
            7'd84: s = 16'h5771;  7'd85: s = 16'h602F;  7'd86: s = 16'h69CE;
            7'd87: s = 16'h7462;
            default: s = 16'h7FFF;
        endcase
        return s;
    endfunction

    function automatic logic signed [7:0] index_adjust(input logic [2:0] mag);
        logic signed [7:0] a;
        case (mag)
            3'd4:    a = 8'sd2;
            3'd5:    a = 8'sd4;
            3'd6:    a = 8'sd6;
            3'd7:    a = 8'sd8;
            default: a = -8'sd1;
        endcase
        return a;
    endfunction

endpackage

// File: hdl/ima_adpcm_nibble_decoder.sv
// channel   dir  tdata                                    tuser
// s_axis    in   [31:0] data                              [1:0] kind
// m_axis    out  [15:0] sample, [22:16] step_index        [0] loop_captured
// cfg       in   i_cfg_wdata [15:0] loop_point_words, written when i_cfg_we
//
// one request per cycle unless m_axis stalls; the result is registered on the next edge
// decode, clamps and step table lookup all sit in one combinational pass from the state
// the output register holds a result while m_axis stalls; a new request enters as it drains
// synchronous active-low reset clears decoder state, saved loop state and the loop point
module ima_adpcm_nibble_decoder
    import imadec_pkg::*;
#(
    parameter int POSITION_BITS = PositionBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,       // loop_point_words
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,    // data
    input  logic [1:0]  i_s_axis_tuser,    // kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,    // sample, step_index, zero pad
    output logic        o_m_axis_tuser     // loop_captured
);

    localparam logic [POSITION_BITS-1:0] PosMax   = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] PosStart = POSITION_BITS'(8);

    logic [LoopBits-1:0]      r_loop;
    logic [SampleBits-1:0]    r_sample,       n_sample;
    logic [IndexBits-1:0]     r_index,        n_index;
    logic [POSITION_BITS-1:0] r_pos,          n_pos;
    logic [SampleBits-1:0]    r_saved_sample, n_saved_sample;
    logic [IndexBits-1:0]     r_saved_index,  n_saved_index;
    logic                     r_valid;
    logic [SampleBits-1:0]    r_out_sample;
    logic [IndexBits-1:0]     r_out_index;
    logic                     r_out_cap,      n_cap;

    logic                     accept;
    t_kind                    kind;
    logic [POSITION_BITS-1:0] loop_pos;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [POSITION_BITS-1:0] restore_pos;
    logic [15:0]              step;
    logic [15:0]              diff;
    logic signed [17:0]       sum;
    logic signed [17:0]       dec_sample;
    logic signed [7:0]        idx_sum;
    logic [IndexBits-1:0]     dec_index;
    logic [IndexBits-1:0]     hdr_index;
    logic [3:0]               nib;

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign kind            = t_kind'(i_s_axis_tuser);
    assign nib             = i_s_axis_tdata[3:0];

    assign loop_pos    = POSITION_BITS'({r_loop, 3'b000});
    assign pos_inc     = (r_pos == PosMax) ? PosMax : r_pos + 1'b1;
    assign restore_pos = (loop_pos == PosMax) ? PosMax : loop_pos + 1'b1;

    // nibble decode
    always_comb begin
        step = step_size(r_index);
        diff = {3'b000, step[15:3]};
        if (nib[0]) begin
            diff = diff + {2'b00, step[15:2]};
        end
        if (nib[1]) begin
            diff = diff + {1'b0, step[15:1]};
        end
        if (nib[2]) begin
            diff = diff + step;
        end
        if (nib[3]) begin
            sum        = 18'(signed'(r_sample)) - signed'({2'b00, diff});
            dec_sample = (sum < SampleMin) ? SampleMin : sum;
        end else begin
            sum        = 18'(signed'(r_sample)) + signed'({2'b00, diff});
            dec_sample = (sum > SampleMax) ? SampleMax : sum;
        end
        idx_sum = signed'({1'b0, r_index}) + index_adjust(nib[2:0]);
        if (idx_sum < 0) begin
            dec_index = '0;
        end else if (idx_sum > signed'({1'b0, MaxIndex})) begin
            dec_index = MaxIndex;
        end else begin
            dec_index = idx_sum[IndexBits-1:0];
        end
    end

    assign hdr_index = (i_s_axis_tdata[22:16] > MaxIndex) ? MaxIndex : i_s_axis_tdata[22:16];

    always_comb begin
        n_sample       = r_sample;
        n_index        = r_index;
        n_pos          = r_pos;
        n_saved_sample = r_saved_sample;
        n_saved_index  = r_saved_index;
        n_cap          = 1'b0;
        case (kind)
            KIND_HEADER: begin
                n_sample = i_s_axis_tdata[15:0];
                n_index  = hdr_index;
                n_pos    = PosStart;
            end
            KIND_NIBBLE: begin
                n_pos = pos_inc;
                // warm-up nibbles only advance the position
                if (r_pos >= PosStart) begin
                    n_sample = dec_sample[SampleBits-1:0];
                    n_index  = dec_index;
                    if (r_pos == loop_pos) begin
                        n_saved_sample = dec_sample[SampleBits-1:0];
                        n_saved_index  = dec_index;
                        n_cap          = 1'b1;
                    end
                end
            end
            KIND_RESTORE: begin
                n_sample = r_saved_sample;
                n_index  = r_saved_index;
                n_pos    = restore_pos;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop         <= '0;
            r_sample       <= '0;
            r_index        <= '0;
            r_pos          <= '0;
            r_saved_sample <= '0;
            r_saved_index  <= '0;
            r_valid        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_loop <= i_cfg_wdata;
            end
            if (accept) begin
                r_sample       <= n_sample;
                r_index        <= n_index;
                r_pos          <= n_pos;
                r_saved_sample <= n_saved_sample;
                r_saved_index  <= n_saved_index;
                r_valid        <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_sample <= n_sample;
            r_out_index  <= n_index;
            r_out_cap    <= n_cap;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_index, r_out_sample};
    assign o_m_axis_tuser  = r_out_cap;

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index <= MaxIndex && r_saved_index <= MaxIndex)
        else $error("step index out of range");

    a_header_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && kind == KIND_HEADER |=> r_pos == PosStart)
        else $error("header did not set position");

    a_restore_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && kind == KIND_RESTORE |=> r_pos == $past(restore_pos))
        else $error("restore position wrong");

    a_capture_saved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_out_cap |->
            r_saved_sample == r_out_sample && r_saved_index == r_out_index)
        else $error("captured result differs from saved state");

endmodule

// File: tb/testbench.sv
module testbench;
    import imadec_pkg::*;

    localparam int QuietLimit    = 3000;
    localparam int HoldOffCycles = 300;
    localparam int RandomTarget  = 550;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [6:0]         index;
        logic               captured;
    } t_dec_result;

    typedef struct packed {
        bit          is_cfg;
        logic [15:0] loop_words;
        t_kind       kind;
        logic [31:0] data;
        bit          typed;
        t_dec_result result;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;

    // decoder shadow state
    logic signed [15:0] dec_sample = '0;
    logic [6:0]         dec_index = '0;
    longint             dec_pos = 0;
    logic signed [15:0] saved_sample = '0;
    logic [6:0]         saved_index = '0;
    logic [15:0]        loop_words = '0;

    t_dec_result pending_results [$];
    int          failures = 0;
    int          quiet_cycles = 0;
    int          requests_sent = 0;
    int          hold_offs_asked = 0;
    int          hold_offs_done = 0;
    bit          send_steady = 1'b0;
    bit          recv_steady = 1'b0;

    logic [15:0] ima_steps [89] = '{
        16'h0007, 16'h0008, 16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h000E,
        16'h0010, 16'h0011, 16'h0013, 16'h0015, 16'h0017, 16'h0019, 16'h001C, 16'h001F,
        16'h0022, 16'h0025, 16'h0029, 16'h002D, 16'h0032, 16'h0037, 16'h003C, 16'h0042,
        16'h0049, 16'h0050, 16'h0058, 16'h0061, 16'h006B, 16'h0076, 16'h0082, 16'h008F,
        16'h009D, 16'h00AD, 16'h00BE, 16'h00D1, 16'h00E6, 16'h00FD, 16'h0117, 16'h0133,
        16'h0151, 16'h0173, 16'h0198, 16'h01C1, 16'h01EE, 16'h0220, 16'h0256, 16'h0292,
        16'h02D4, 16'h031C, 16'h036C, 16'h03C3, 16'h0424, 16'h048E, 16'h0502, 16'h0583,
        16'h0610, 16'h06AB, 16'h0756, 16'h0812, 16'h08E0, 16'h09C3, 16'h0ABD, 16'h0BD0,
        16'h0CFF, 16'h0E4C, 16'h0FBA, 16'h114C, 16'h1307, 16'h14EE, 16'h1706, 16'h1954,
        16'h1BDC, 16'h1EA5, 16'h21B6, 16'h2515, 16'h28CA, 16'h2CDF, 16'h315B, 16'h364B,
        16'h3BB9, 16'h41B2, 16'h4844, 16'h4F7E, 16'h5771, 16'h602F, 16'h69CE, 16'h7462,
        16'h7FFF
    };

    int nibble_index_shift [8] = '{-1, -1, -1, -1, 2, 4, 6, 8};

    t_stim_row directed_rows [22] = '{
        '{1'b0, 16'd0, KIND_NONE,    32'hFFFF_FFFF, 1'b1, '{16'h0000, 7'd0,  1'b0}},
        '{1'b0, 16'd0, KIND_RESTORE, 32'h0000_0000, 1'b1, '{16'h0000, 7'd0,  1'b0}},
        '{1'b0, 16'd0, KIND_NIBBLE,  32'hFFFF_FFFF, 1'b1, '{16'h0000, 7'd0,  1'b0}},
        '{1'b0, 16'd0, KIND_HEADER,  32'h007F_7FFF, 1'b1, '{16'h7FFF, 7'd88, 1'b0}},
        '{1'b0, 16'd0, KIND_NIBBLE,  32'h0000_0007, 1'b1, '{16'h7FFF, 7'd88, 1'b0}},
        '{1'b0, 16'd0, KIND_HEADER,  32'hFFD8_8000, 1'b1, '{16'h8000, 7'd88, 1'b0}},
        '{1'b0, 16'd0, KIND_NIBBLE,  32'h0000_000F, 1'b1, '{16'h8001, 7'd88, 1'b0}},
        '{1'b0, 16'd0, KIND_HEADER,  32'h0000_0000, 1'b1, '{16'h0000, 7'd0,  1'b0}},
        '{1'b0, 16'd0, KIND_NIBBLE,  32'h0000_0000, 1'b0, '0},
        '{1'b0, 16'd0, KIND_NIBBLE,  32'h0000_0001, 1'b0, '0},
        '{1'b0, 16'd0, KIND_NIBBLE,  32'h0000_0002, 1'b0, '0},
        '{1'b0, 16'd0, KIND_NIBBLE,  32'h0000_0004, 1'b0, '0},
        '{1'b0, 16'd0, KIND_NIBBLE,  32'h0000_0008, 1'b0, '0},
        '{1'b0, 16'd0, KIND_NIBBLE,  32'h0000_0007, 1'b0, '0},
        '{1'b0, 16'd0, KIND_NIBBLE,  32'h0000_000C, 1'b0, '0},
        '{1'b0, 16'd0, KIND_NIBBLE,  32'h0000_000F, 1'b0, '0},
        '{1'b1, 16'd1, KIND_NONE,    32'h0000_0000, 1'b0, '0},
        '{1'b0, 16'd0, KIND_HEADER,  32'h0010_1234, 1'b0, '0},
        '{1'b0, 16'd0, KIND_NIBBLE,  32'h0000_0005, 1'b0, '0},
        '{1'b0, 16'd0, KIND_NIBBLE,  32'h0000_000A, 1'b0, '0},
        '{1'b0, 16'd0, KIND_RESTORE, 32'h0000_0000, 1'b0, '0},
        '{1'b0, 16'd0, KIND_NIBBLE,  32'h0000_0002, 1'b0, '0}
    };

    ima_adpcm_nibble_decoder DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clip_position(input longint pos);
        longint top;
        top = (longint'(1) << PositionBitsDefault) - 1;
        return (pos > top) ? top : pos;
    endfunction

    function automatic t_dec_result predict_decode(input t_kind kind, input logic [31:0] data);
        t_dec_result res;
        longint      loop_nib;
        longint      here;
        int          step_val;
        int          diff;
        int          acc;
        int          next_index;
        res.captured = 1'b0;
        loop_nib = longint'(loop_words) * 8;
        case (kind)
            KIND_HEADER: begin
                dec_sample = data[15:0];
                dec_index  = (data[22:16] > MaxIndex) ? MaxIndex : data[22:16];
                dec_pos    = clip_position(8);
            end
            KIND_NIBBLE: begin
                here = dec_pos;
                if (here >= 8) begin
                    step_val = ima_steps[dec_index];
                    diff = step_val >> 3;
                    if (data[0]) diff += step_val >> 2;
                    if (data[1]) diff += step_val >> 1;
                    if (data[2]) diff += step_val;
                    acc = int'(dec_sample);
                    if (data[3]) begin
                        acc -= diff;
                        if (acc < -32767) acc = -32767;
                    end else begin
                        acc += diff;
                        if (acc > 32767) acc = 32767;
                    end
                    dec_sample = acc[15:0];
                    next_index = int'(dec_index) + nibble_index_shift[data[2:0]];
                    if (next_index < 0) next_index = 0;
                    else if (next_index > 88) next_index = 88;
                    dec_index = next_index[6:0];
                    if (here == loop_nib) begin
                        saved_sample = dec_sample;
                        saved_index  = dec_index;
                        res.captured = 1'b1;
                    end
                end
                dec_pos = clip_position(here + 1);
            end
            KIND_RESTORE: begin
                dec_sample = saved_sample;
                dec_index  = saved_index;
                dec_pos    = clip_position(loop_nib + 1);
            end
            default: begin
            end
        endcase
        res.sample = dec_sample;
        res.index  = dec_index;
        return res;
    endfunction

    function automatic int idle_cycles(input bit steady);
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic offer(input t_kind kind, input logic [31:0] data, input bit typed,
                         input t_dec_result typed_res);
        int          gap;
        t_dec_result predicted;
        gap = idle_cycles(send_steady);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = predict_decode(kind, data);
        pending_results.push_back(typed ? typed_res : predicted);
        if (kind != KIND_NONE) requests_sent++;
    endtask

    // waits until every result has drained, then writes the loop point
    task automatic write_loop_point(input logic [15:0] value);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        loop_words = value;
    endtask

    task automatic random_request;
        int roll;
        roll = $urandom_range(0, 39);
        if (roll == 0) offer(KIND_RESTORE, $urandom(), 1'b0, '0);
        else if (roll == 1) offer(KIND_NONE, $urandom(), 1'b0, '0);
        else if (roll == 2) offer(KIND_HEADER, $urandom(), 1'b0, '0);
        else offer(KIND_NIBBLE, $urandom(), 1'b0, '0);
    endtask

    initial begin : stimulus
        int          phase;
        int          roll;
        int          nibbles;
        logic [15:0] loop_val;
        logic [31:0] hdr;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) write_loop_point(directed_rows[i].loop_words);
            else offer(directed_rows[i].kind, directed_rows[i].data, directed_rows[i].typed,
                       directed_rows[i].result);
        end

        requests_sent = 0;
        phase = 0;
        while (requests_sent < RandomTarget) begin
            send_steady = ($urandom_range(0, 4) == 0);
            recv_steady = ($urandom_range(0, 4) == 0);
            if (phase == 0 || phase == 5) begin
                send_steady = 1'b1;
            end
            if (phase == 0) loop_val = 16'hFFFF;
            else if (phase == 1) loop_val = 16'h0000;
            else begin
                roll = $urandom_range(0, 9);
                if (roll == 0) loop_val = 16'h0000;
                else if (roll == 1) loop_val = 16'hFFFF;
                else if (roll == 2) loop_val = $urandom_range(0, 65535);
                else loop_val = $urandom_range(1, 6);
            end
            // restore just below the loop point, then walk up to it
            if (loop_val != 0 && (phase == 0 || $urandom_range(0, 3) == 0)) begin
                write_loop_point(loop_val - 16'd1);
                offer(KIND_RESTORE, $urandom(), 1'b0, '0);
                write_loop_point(loop_val);
                repeat ($urandom_range(8, 12)) offer(KIND_NIBBLE, $urandom(), 1'b0, '0);
            end else begin
                write_loop_point(loop_val);
            end
            // in phases 0 and 5 the receiver holds off while the requests below keep coming
            if (phase == 0 || phase == 5) begin
                hold_offs_asked++;
            end
            repeat ($urandom_range(1, 4)) begin
                hdr = $urandom();
                if ($urandom_range(0, 1) == 1) hdr[22:16] = $urandom_range(0, 88);
                offer(KIND_HEADER, hdr, 1'b0, '0);
                nibbles = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                      : $urandom_range(3, 40);
                repeat (nibbles) random_request();
            end
            phase++;
        end

        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : receiver
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_offs_done != hold_offs_asked) begin
                i_m_axis_tready <= 1'b0;
                repeat (HoldOffCycles) @(posedge i_clk);
                hold_offs_done++;
            end else begin
                stall = idle_cycles(recv_steady);
                if (stall > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_dec_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: tdata %h", o_m_axis_tdata);
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata[15:0] !== want.sample) begin
                    $error("sample: expected %0d, got %0d", want.sample,
                           $signed(o_m_axis_tdata[15:0]));
                    failures++;
                end
                if (o_m_axis_tdata[22:16] !== want.index) begin
                    $error("step_index: expected %0d, got %0d", want.index,
                           o_m_axis_tdata[22:16]);
                    failures++;
                end
                if (o_m_axis_tuser !== want.captured) begin
                    $error("loop_captured: expected %0d, got %0d", want.captured,
                           o_m_axis_tuser);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QuietLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
